@@ rtl/core/nes_pkg.sv @@
// Shared constants, types and control structs for the note envelope shaper.
package nes_pkg;

  localparam int SAMPLE_RATE  = 44100;
  localparam int SAMPLE_BITS  = 16;
  localparam int REG_W        = 24;
  localparam int CFG_IDX_W    = 2;
  // 0.07 s rounded to the nearest sample
  localparam int SHORT_ATTACK = (SAMPLE_RATE * 7 + 50) / 100;
  // numerator and divisor span: up to 3 * release or attack + decay
  localparam int NUM_W        = REG_W + 2;
  localparam int QUO_W        = SAMPLE_BITS;
  localparam int PROD_W       = SAMPLE_BITS + NUM_W;
  localparam int DIV_STEPS    = QUO_W;
  localparam int CNT_W        = $clog2(DIV_STEPS);
  localparam int LANES        = 2;

  localparam logic [REG_W-1:0] NOTE_RST    = REG_W'(22050);
  localparam logic [REG_W-1:0] ATTACK_RST  = REG_W'(4410);
  localparam logic [REG_W-1:0] DECAY_RST   = REG_W'(17640);
  localparam logic [REG_W-1:0] RELEASE_RST = REG_W'(5072);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOTE    = 2'd0,
    REG_ATTACK  = 2'd1,
    REG_DECAY   = 2'd2,
    REG_RELEASE = 2'd3
  } cfg_reg_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_SEL  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;
    logic prep;
    logic sel;
    logic mul;
    logic step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

@@ rtl/core/nes_ctrl.sv @@
// Sequencer for the envelope shaper: handshakes and datapath commands.
module nes_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  nes_pkg::dp_status_t status_i,
  output nes_pkg::ctrl_cmd_t  cmd_o
);

  nes_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      nes_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = nes_pkg::ST_PREP;
        end
      end
      nes_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = nes_pkg::ST_SEL;
      end
      nes_pkg::ST_SEL: begin
        cmd_o.sel = 1'b1;
        state_d   = nes_pkg::ST_MUL;
      end
      nes_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = nes_pkg::ST_DIV;
      end
      nes_pkg::ST_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.div_done) state_d = nes_pkg::ST_OUT;
      end
      nes_pkg::ST_OUT: begin
        // wait until the output register is empty or being drained
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = nes_pkg::ST_IDLE;
        end
      end
      default: state_d = nes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nes_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != nes_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/core/nes_dpath.sv @@
// Envelope datapath: registers, time counter, gain select, multiply, serial divide.
module nes_dpath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [nes_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [nes_pkg::REG_W-1:0]             cfg_data_i,
  input  logic                                  restart_i,
  input  logic signed [nes_pkg::SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [nes_pkg::SAMPLE_BITS-1:0] right_in_i,
  input  nes_pkg::ctrl_cmd_t                    cmd_i,
  output nes_pkg::dp_status_t                   status_o,
  output logic signed [nes_pkg::SAMPLE_BITS-1:0] left_out_o,
  output logic signed [nes_pkg::SAMPLE_BITS-1:0] right_out_o,
  output logic                                  sounding_o
);

  localparam int RW = nes_pkg::REG_W;
  localparam int NW = nes_pkg::NUM_W;
  localparam int SB = nes_pkg::SAMPLE_BITS;
  localparam int QW = nes_pkg::QUO_W;
  localparam int PW = nes_pkg::PROD_W;
  localparam int CW = nes_pkg::CNT_W;
  localparam int NL = nes_pkg::LANES;

  // configuration and time state
  logic [RW-1:0] note_q, attack_q, decay_q, release_q;
  logic [RW-1:0] time_q, time_d;

  // effective lengths after the short-note rules
  logic [RW-1:0] te_q, ae_q, re_q, dce_q;
  logic          sound_q;

  logic [NW-1:0] num_q, den_q;
  logic [SB-1:0] x_q   [NL];
  logic [SB-1:0] mag_q [NL];
  logic          neg_q [NL];
  logic [NW-1:0] rem_q [NL];
  logic [QW-1:0] lo_q  [NL];
  logic [CW-1:0] cnt_q;
  logic [SB-1:0] y_q   [NL];
  logic          sounding_q;

  // prep stage
  logic [RW+2:0] d_x5;
  logic          short5, short2;
  logic [RW-1:0] a_s, r_s, dc_s, a_e, r_e, te_d;
  logic          sound_d;

  always_comb begin
    d_x5   = {1'b0, note_q, 2'b00} + {3'b000, note_q};
    short5 = d_x5 < (RW+3)'(nes_pkg::SAMPLE_RATE);
    short2 = {note_q, 1'b0} < (RW+1)'(nes_pkg::SAMPLE_RATE);
    a_s    = short5 ? RW'(nes_pkg::SHORT_ATTACK) : attack_q;
    r_s    = release_q;
    dc_s   = decay_q;
    if (short2) begin
      dc_s = '0;
      r_s  = (a_s < note_q) ? note_q - a_s : RW'(1);
    end
    a_e     = (a_s == '0) ? RW'(1) : a_s;
    r_e     = (r_s == '0) ? RW'(1) : r_s;
    te_d    = (time_q < note_q) ? time_q : note_q;
    time_d  = (time_q < note_q) ? time_q + RW'(1) : note_q;
    sound_d = time_d < note_q;
  end

  // segment select stage
  logic          rel, in_att, in_dec;
  logic [RW-1:0] since_a;
  logic [NW-1:0] since_x3, dc_x2, r_x3, num_d, den_d;

  always_comb begin
    rel      = ({1'b0, te_q} + {1'b0, re_q}) > {1'b0, note_q};
    in_att   = te_q < ae_q;
    since_a  = te_q - ae_q;
    since_x3 = {1'b0, since_a, 1'b0} + {2'b00, since_a};
    dc_x2    = {1'b0, dce_q, 1'b0};
    in_dec   = since_x3 < dc_x2;
    r_x3     = {1'b0, re_q, 1'b0} + {2'b00, re_q};
    if (rel) begin
      num_d = NW'(note_q - te_q);
      den_d = (dce_q != '0) ? r_x3 : {2'b00, re_q};
    end else if (in_att) begin
      num_d = {2'b00, te_q};
      den_d = {2'b00, ae_q};
    end else if (in_dec) begin
      num_d = {2'b00, ae_q} + {2'b00, dce_q} - {2'b00, te_q};
      den_d = {2'b00, dce_q};
    end else begin
      // sustain at one third
      num_d = NW'(1);
      den_d = NW'(3);
    end
  end

  // multiply and restoring divide, one lane per channel
  logic [PW-1:0] prod  [NL];
  logic [NW:0]   trial [NL];
  logic          ge    [NL];
  logic [SB-1:0] y_d   [NL];

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      prod[i]  = {{NW{1'b0}}, mag_q[i]} * {{SB{1'b0}}, num_q};
      trial[i] = {rem_q[i], lo_q[i][QW-1]};
      ge[i]    = trial[i] >= {1'b0, den_q};
      y_d[i]   = neg_q[i] ? SB'(~lo_q[i] + 1'b1) : SB'(lo_q[i]);
    end
  end

  assign status_o.div_done = (cnt_q == CW'(nes_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_q    <= nes_pkg::NOTE_RST;
      attack_q  <= nes_pkg::ATTACK_RST;
      decay_q   <= nes_pkg::DECAY_RST;
      release_q <= nes_pkg::RELEASE_RST;
      time_q    <= '0;
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (nes_pkg::cfg_reg_e'(cfg_idx_i))
          nes_pkg::REG_NOTE:    note_q    <= cfg_data_i;
          nes_pkg::REG_ATTACK:  attack_q  <= cfg_data_i;
          nes_pkg::REG_DECAY:   decay_q   <= cfg_data_i;
          nes_pkg::REG_RELEASE: release_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load && restart_i) time_q <= '0;
      if (cmd_i.prep) time_q <= time_d;
      if (cmd_i.mul) cnt_q <= '0;
      else if (cmd_i.step) cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q[0] <= left_in_i;
      x_q[1] <= right_in_i;
    end
    if (cmd_i.prep) begin
      te_q    <= te_d;
      ae_q    <= a_e;
      re_q    <= r_e;
      dce_q   <= dc_s;
      sound_q <= sound_d;
    end
    if (cmd_i.sel) begin
      num_q <= num_d;
      den_q <= den_d;
      for (int i = 0; i < NL; i++) begin
        neg_q[i] <= x_q[i][SB-1];
        mag_q[i] <= x_q[i][SB-1] ? ~x_q[i] + 1'b1 : x_q[i];
      end
    end
    for (int i = 0; i < NL; i++) begin
      if (cmd_i.mul) begin
        // quotient fits in QW bits, so the upper part starts below the divisor
        rem_q[i] <= prod[i][PW-1:QW];
        lo_q[i]  <= prod[i][QW-1:0];
      end else if (cmd_i.step) begin
        rem_q[i] <= ge[i] ? NW'(trial[i] - {1'b0, den_q}) : trial[i][NW-1:0];
        lo_q[i]  <= {lo_q[i][QW-2:0], ge[i]};
      end
      if (cmd_i.out_load) y_q[i] <= y_d[i];
    end
    if (cmd_i.out_load) sounding_q <= sound_q;
  end

  assign left_out_o  = y_q[0];
  assign right_out_o = y_q[1];
  assign sounding_o  = sounding_q;

endmodule

@@ rtl/core/note_envelope_shaper.sv @@
// Note envelope shaper: ADSR-style gain on a stereo sample pair per item.
// Each item passes through prep, select, multiply, 16 restoring-divide steps on the
// shared divisor and output load before its result is valid in the output register.
// Items do not overlap: a new item waits until the last has left the serial divide loop
// and been loaded; the next item is taken while a finished result waits in the output register.
// Reset clears the sample-time counter and restores the register defaults.
module note_envelope_shaper (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [nes_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [nes_pkg::REG_W-1:0]              cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   restart_i,
  input  logic signed [nes_pkg::SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [nes_pkg::SAMPLE_BITS-1:0] right_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [nes_pkg::SAMPLE_BITS-1:0] left_out_o,
  output logic signed [nes_pkg::SAMPLE_BITS-1:0] right_out_o,
  output logic                                   sounding_o
);

  nes_pkg::ctrl_cmd_t  cmd;
  nes_pkg::dp_status_t status;

  nes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nes_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .restart_i   (restart_i),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .sounding_o  (sounding_o)
  );

  // an accepted item keeps the input side busy while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accept");

  // a new result only appears at the end of work in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o) && !$past(cmd.load))
    else $error("result without an item in flight");

  // an output load only follows a divide step or a busy cycle without an output load
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> $past(cmd.step) || $past(cmd.out_load == 1'b0 && in_stall_o))
    else $error("output load outside the divide sequence");

endmodule

@@ tb/sv/tb_note_envelope_shaper.sv @@
// Self-checking testbench for note_envelope_shaper: envelope gain predictor and scoreboard.
module tb_note_envelope_shaper;
  import nes_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1650;
  localparam int REG_MAX = (1 << REG_W) - 1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          sounding;
  } shaped_pair_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  cfg_reg_e                      cfg_idx = REG_NOTE;
  logic [REG_W-1:0]              cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          restart = 1'b0;
  logic signed [SAMPLE_BITS-1:0] left_in = '0;
  logic signed [SAMPLE_BITS-1:0] right_in = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          sounding;

  // predictor copy of the registers and the sample-time counter
  longint note_len = 22050;
  longint attack_len = 4410;
  longint decay_len = 17640;
  longint release_len = 5072;
  longint time_now = 0;

  shaped_pair_t pending_pairs[$];
  bit calm = 1'b0;
  int cycles = 0;
  int mismatches = 0;
  int items_sent = 0;
  int pairs_checked = 0;
  int settings_used = 0;

  note_envelope_shaper u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .restart_i   (restart),
    .left_in_i   (left_in),
    .right_in_i  (right_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .left_out_o  (left_out),
    .right_out_o (right_out),
    .sounding_o  (sounding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_pairs.size());
    $display("status: fail");
    $finish;
  end

  // Gain for one item; advances the sample-time counter like the block does.
  function automatic shaped_pair_t shape_sample(input bit clear_time,
                                                input logic signed [SAMPLE_BITS-1:0] xl,
                                                input logic signed [SAMPLE_BITS-1:0] xr);
    longint d, a, dc, r, te, num, den, lx, rx;
    shaped_pair_t res;
    d = note_len;
    a = attack_len;
    dc = decay_len;
    r = release_len;
    lx = longint'(xl);
    rx = longint'(xr);
    if (clear_time) time_now = 0;
    if (5 * d < SAMPLE_RATE) a = SHORT_ATTACK;
    if (2 * d < SAMPLE_RATE) begin
      dc = 0;
      r = (a < d) ? d - a : 1;
    end
    if (a == 0) a = 1;
    if (r == 0) r = 1;
    te = (time_now < d) ? time_now : d;
    if (te + r > d) begin
      num = d - te;
      den = (dc != 0) ? 3 * r : r;
    end else if (te < a) begin
      num = te;
      den = a;
    end else if (3 * (te - a) < 2 * dc) begin
      num = a + dc - te;
      den = dc;
    end else begin
      num = 1;
      den = 3;
    end
    // signed longint division truncates toward zero
    res.left = SAMPLE_BITS'((lx * num) / den);
    res.right = SAMPLE_BITS'((rx * num) / den);
    time_now = (time_now < d) ? time_now + 1 : d;
    res.sounding = (time_now < d);
    return res;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_pair(input bit clear_time,
                           input logic signed [SAMPLE_BITS-1:0] l,
                           input logic signed [SAMPLE_BITS-1:0] r);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 20) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart <= clear_time;
    left_in <= l;
    right_in <= r;
    do @(posedge clk); while (in_stall);
    pending_pairs.push_back(shape_sample(clear_time, l, r));
    items_sent++;
  endtask

  task automatic send_run(input int count, input bit clear_first);
    for (int i = 0; i < count; i++)
      send_pair((i == 0) ? clear_first : ($urandom_range(0, 39) == 0), pick_sample(),
                pick_sample());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four registers; only called with the block drained.
  task automatic set_envelope(input int unsigned d, input int unsigned a,
                              input int unsigned dc, input int unsigned r);
    cfg_reg_e idx_list[4];
    int unsigned val_list[4];
    idx_list = '{REG_NOTE, REG_ATTACK, REG_DECAY, REG_RELEASE};
    val_list = '{d, a, dc, r};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx_list[i];
      cfg_data <= REG_W'(val_list[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    note_len = longint'(d & REG_MAX);
    attack_len = longint'(a & REG_MAX);
    decay_len = longint'(dc & REG_MAX);
    release_len = longint'(r & REG_MAX);
    settings_used++;
  endtask

  always @(posedge clk) begin : check_results
    shaped_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result L=%0d R=%0d snd=%0b", left_out, right_out, sounding);
      end else begin
        want = pending_pairs.pop_front();
        pairs_checked++;
        if (left_out !== want.left || right_out !== want.right || sounding !== want.sounding)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: exp L=%0d R=%0d snd=%0b, got L=%0d R=%0d snd=%0b",
                     pairs_checked, want.left, want.right, want.sounding,
                     left_out, right_out, sounding);
        end
      end
    end
  end

  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 20);

  // reset register values, full-scale, zero and minus-one samples
  task automatic test_defaults();
    send_pair(1'b1, 16'sh7fff, 16'sh8000);
    send_pair(1'b0, 16'sh8000, 16'sh7fff);
    send_pair(1'b0, '0, '1);
  endtask

  // attack not shorter than the note forces a one-sample release
  task automatic test_short_note();
    drain();
    set_envelope(3, REG_MAX, REG_MAX, REG_MAX);
    send_pair(1'b1, 16'sh7fff, 16'sh8000);
    send_pair(1'b0, 16'sh7fff, 16'sh8000);
    send_pair(1'b0, 16'sh7fff, 16'sh8000);
    send_pair(1'b0, 16'sh7fff, 16'sh8000);
  endtask

  // release at least as long as the note, with and without decay
  task automatic test_long_release();
    drain();
    set_envelope(22050, REG_MAX, REG_MAX, REG_MAX);
    send_pair(1'b1, 16'sh8000, 16'sh7fff);
    send_pair(1'b0, 16'sh8000, 16'sh7fff);
    drain();
    set_envelope(REG_MAX, 1, 0, REG_MAX);
    send_pair(1'b1, 16'sh7fff, 16'sh8000);
    send_pair(1'b0, 16'sh7fff, 16'sh8000);
  endtask

  // attack, decay and sustain in a few samples
  task automatic test_segments();
    drain();
    set_envelope(30000, 2, 3, 1);
    send_pair(1'b1, 16'sh7fff, 16'sh8000);
    for (int i = 0; i < 6; i++) send_pair(1'b0, 16'sh7fff, 16'sh8000);
  endtask

  // note length lowered below the running time
  task automatic test_time_past_length();
    drain();
    set_envelope(2, 1, 0, 1);
    send_pair(1'b1, 16'sh7fff, 16'sh8000);
    send_pair(1'b0, 16'sh7fff, 16'sh8000);
    drain();
    set_envelope(1, 1, 0, 1);
    send_pair(1'b0, 16'sh7fff, 16'sh8000);
    send_pair(1'b0, 16'sh7fff, 16'sh8000);
  endtask

  task automatic test_random_envelopes();
    int start, d, a, dc, r, k;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      calm = (items_sent - start > 700) && (items_sent - start < 950);
      drain();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // long note: walk attack/decay/sustain, then pull the release in
          d = ($urandom_range(0, 7) == 0) ? REG_MAX : $urandom_range(22050, 80000);
          a = $urandom_range(1, 12);
          dc = $urandom_range(0, 20);
          set_envelope(d, a, dc, $urandom_range(1, 30));
          send_run($urandom_range(5, 50), 1'b1);
          drain();
          r = int'(note_len - time_now) - $urandom_range(0, 12);
          set_envelope(d, a, dc, (r < 1) ? 1 : r);
          send_run($urandom_range(5, 30), 1'b0);
        end
        4, 5, 6: begin
          d = $urandom_range(1, 120);
          set_envelope(d, $urandom_range(1, REG_MAX), $urandom_range(0, REG_MAX),
                       $urandom_range(1, REG_MAX));
          send_run(d + $urandom_range(0, 6), 1'b1);
          if ($urandom_range(0, 1) == 0 && time_now > 1) begin
            k = $urandom_range(1, int'(time_now) - 1);
            drain();
            set_envelope(k, int'(attack_len), int'(decay_len), int'(release_len));
            send_run(3, 1'b0);
          end
        end
        7, 8: begin
          d = $urandom_range(8820, 22049);
          a = ($urandom_range(0, 3) == 0) ? $urandom_range(d, REG_MAX) : $urandom_range(1, 40);
          set_envelope(d, a, $urandom_range(0, REG_MAX), $urandom_range(1, REG_MAX));
          send_run($urandom_range(10, 40), 1'b1);
        end
        default: begin
          set_envelope($urandom_range(3088, 8819), $urandom_range(1, REG_MAX),
                       $urandom_range(0, REG_MAX), $urandom_range(1, REG_MAX));
          send_run($urandom_range(10, 40), 1'b1);
        end
      endcase
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_short_note();
    test_long_release();
    test_segments();
    test_time_past_length();
    test_random_envelopes();
    drain();
    repeat (30) @(posedge clk);
    if (pending_pairs.size() != 0) mismatches++;
    $display("sent %0d sample pairs over %0d envelope settings, checked %0d results",
             items_sent, settings_used, pairs_checked);
    $display("short, mid and long notes; all four gain segments; %0d mismatches", mismatches);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/nes_pkg.sv
rtl/core/nes_ctrl.sv
rtl/core/nes_dpath.sv
rtl/core/note_envelope_shaper.sv
tb/sv/tb_note_envelope_shaper.sv
